[rtl/core/ptc_pkg.sv]
// Package for the pressure-to-torque conditioner: widths, codes, helper types.
// No dependencies; imported by every module under rtl/core.
package ptc_pkg;
	localparam int CHANNELS = 4;
	localparam int CH_W = 2;
	localparam int LOAD_FRAC_BITS = 14;
	localparam int SAMPLE_W = 12;
	localparam int FILT_W = 28;
	localparam int LOAD_W = 15;
	localparam int TORQUE_W = 14;
	localparam int SUM_W = 28;
	localparam int CNT_W = 16;
	localparam logic [LOAD_W-1:0] LOAD_ONE = LOAD_W'(1 << LOAD_FRAC_BITS);
	localparam logic [LOAD_W-1:0] LOAD_MAX = LOAD_W'(3 << (LOAD_FRAC_BITS - 1));
	localparam logic [SAMPLE_W-1:0] LOADED_DEFAULT = 12'd1000;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_UNLOADED = 2'd1;
	localparam logic [1:0] PH_LOADED = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_PAIR = 3'd1;
	localparam logic [2:0] REG_MAX_TORQUE = 3'd2;
	localparam logic [2:0] REG_ON_THR = 3'd3;
	localparam logic [2:0] REG_OFF_THR = 3'd4;
	localparam logic [2:0] REG_ALPHA = 3'd5;
	localparam logic [2:0] REG_CAL_DUR = 3'd6;
	localparam logic [2:0] REG_MIN_SPAN = 3'd7;

	// per-channel record held in the state memory
	typedef struct packed {
		logic [FILT_W-1:0]   filt;
		logic [SAMPLE_W-1:0] unloaded;
		logic [SAMPLE_W-1:0] loaded;
		logic [LOAD_W-1:0]   load;
		logic                contact;
		logic [SUM_W-1:0]    sum;
	} ch_rec_t;

	// divider request / response
	typedef struct packed {
		logic        start;
		logic [45:0] num;
		logic [33:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [45:0] quo;
	} div_rsp_t;
endpackage

[rtl/core/ptc_divider.sv]
// Restoring divider, one quotient bit per cycle; produces a 46-bit quotient.
// Depends on ptc_pkg.
module ptc_divider
	import ptc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [45:0] quo_q;
	logic [46:0] rem_q;
	logic [33:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [46:0] shifted;
	logic [46:0] diff;

	always_comb begin
		shifted = {rem_q[45:0], quo_q[45]};
		diff = shifted - {13'd0, den_q};
	end

	// one bit per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == 6'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd46;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!diff[46]) begin
				rem_q <= diff;
				quo_q <= {quo_q[44:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[44:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
endmodule

[rtl/core/ptc_state_mem.sv]
// Per-channel state memory, one write and one read port, registered read.
// Depends on ptc_pkg.
module ptc_state_mem
	import ptc_pkg::*;
(
	input  logic            clk,
	input  logic            we,
	input  logic [CH_W-1:0] waddr,
	input  ch_rec_t         wdata,
	input  logic [CH_W-1:0] raddr,
	output ch_rec_t         rdata
);
	ch_rec_t mem [CHANNELS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/pressure_to_torque_conditioner.sv]
// Pressure-to-torque conditioner top level: sequencer, config, output register.
// An assist tick that ends a calibration runs up to two divides per channel, a normal
// assist tick at most one, and a tick without assist none: it skips the channel loop.
// Each divide uses the shared 46-step divider; one tick at a time.
// Throughput: a new tick is taken the cycle after the previous result beat has left.
// After arst_n low, a sweep over all channels writes default levels before the first beat.
module pressure_to_torque_conditioner
	import ptc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: assist_active, sample_ch0..3, reset_click, unloaded_click, loaded_click
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: right_torque, left_torque, load_ch0..3, contact_mask, cal_phase
	output logic [95:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_CTRL = 4'd2;
	localparam logic [3:0] ST_RD = 4'd3;
	localparam logic [3:0] ST_WAIT = 4'd4;
	localparam logic [3:0] ST_AVG = 4'd5;
	localparam logic [3:0] ST_AVGW = 4'd6;
	localparam logic [3:0] ST_FILT = 4'd7;
	localparam logic [3:0] ST_NORM = 4'd8;
	localparam logic [3:0] ST_NORMW = 4'd9;
	localparam logic [3:0] ST_WB = 4'd10;
	localparam logic [3:0] ST_TORQ = 4'd11;
	localparam logic [3:0] ST_OUT = 4'd12;

	// configuration registers
	logic        en_q, pair_q;
	logic [13:0] maxt_q;
	logic [14:0] on_q, off_q;
	logic [15:0] alpha_q, dur_q;
	logic [11:0] span_min_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			pair_q <= 1'b0;
			maxt_q <= 14'd2500;
			on_q <= 15'd5734;
			off_q <= 15'd3277;
			alpha_q <= 16'd7314;
			dur_q <= 16'd3000;
			span_min_q <= 12'd50;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ENABLE: en_q <= cfg_data[0];
				REG_PAIR: pair_q <= cfg_data[0];
				REG_MAX_TORQUE: maxt_q <= cfg_data[13:0];
				REG_ON_THR: on_q <= cfg_data[14:0];
				REG_OFF_THR: off_q <= cfg_data[14:0];
				REG_ALPHA: alpha_q <= cfg_data;
				REG_CAL_DUR: dur_q <= cfg_data;
				REG_MIN_SPAN: span_min_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// control state
	logic [3:0]  st_q;
	logic [CH_W-1:0] ch_q;
	logic [1:0]  phase_q;
	logic        seeded_q;
	logic [15:0] samples_q, elapsed_q;
	logic [55:0] in_q;
	// per-tick actions decided in ST_CTRL
	logic        act_restore_q, act_begin_q, act_accum_q, act_avg_q, act_proc_q;
	logic        seed_tick_q;
	logic [1:0]  avg_phase_q;
	logic [13:0] rt_q, lt_q;
	logic [LOAD_W-1:0] ld_q [CHANNELS];
	logic [CHANNELS-1:0] ct_q;
	logic        mvalid_q;
	logic [95:0] mdata_q;

	ch_rec_t rd, wdata, rec_q;
	logic    we;
	div_req_t dreq;
	div_rsp_t drsp;

	ptc_state_mem u_mem (
		.clk(clk), .we(we), .waddr(ch_q), .wdata(wdata), .raddr(ch_q), .rdata(rd)
	);
	ptc_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic running, assist, c_rst, c_unl, c_ld;
	logic [11:0] x;
	assign running = (phase_q == PH_UNLOADED) || (phase_q == PH_LOADED);
	assign assist = in_q[0];
	assign c_rst = in_q[49];
	assign c_unl = in_q[50];
	assign c_ld = in_q[51];
	always_comb begin
		case (ch_q)
			2'd0: x = in_q[12:1];
			2'd1: x = in_q[24:13];
			2'd2: x = in_q[36:25];
			default: x = in_q[48:37];
		endcase
	end

	// click decode and end of a calibration phase
	logic [15:0] elapsed_nx;
	logic        cal_end, do_restore, do_begin;
	assign elapsed_nx = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
	assign cal_end = elapsed_nx >= dur_q;
	assign do_restore = c_rst && !running;
	assign do_begin = !c_rst && (c_unl || c_ld) && !running;

	// filter step on the fetched record
	logic [27:0] f0, tgt, fnew;
	logic [27:0] dmag;
	logic [43:0] prod;
	logic [27:0] qstep;
	always_comb begin
		f0 = seed_tick_q ? {x, 16'd0} : rec_q.filt;
		tgt = {x, 16'd0};
		dmag = (tgt >= f0) ? tgt - f0 : f0 - tgt;
		prod = dmag * alpha_q + 44'h8000;
		qstep = prod[43:16];
		fnew = (tgt >= f0) ? f0 + qstep : f0 - qstep;
	end

	// normalize numerator/denominator
	logic signed [29:0] num_s;
	logic signed [13:0] span_s;
	logic [12:0] span_u;
	always_comb begin
		num_s = $signed({2'b00, rec_q.filt}) - $signed({2'b00, rec_q.unloaded, 16'd0});
		span_s = $signed({2'b00, rec_q.loaded}) - $signed({2'b00, rec_q.unloaded});
		if (span_s < $signed({2'b00, span_min_q})) span_u = {1'b0, span_min_q};
		else span_u = span_s[12:0];
		if (span_u == 13'd0) span_u = 13'd1;
	end

	// contact update
	logic [LOAD_W-1:0] ldn;
	logic cnew;
	always_comb begin
		if (drsp.quo > {31'd0, LOAD_MAX}) ldn = LOAD_MAX;
		else ldn = drsp.quo[LOAD_W-1:0];
		if (num_s <= 0) ldn = '0;
		cnew = rec_q.contact ? !(ldn <= off_q) : (ldn >= on_q);
	end

	// torque of one channel
	function automatic logic [13:0] torq(input logic [14:0] l, input logic [13:0] m);
		logic [14:0] lc;
		logic [28:0] p;
		begin
			lc = (l > LOAD_ONE) ? LOAD_ONE : l;
			p = lc * m + 29'h2000;
			return p[27:14];
		end
	endfunction

	logic [27:0] avg_sum;
	assign avg_sum = rec_q.sum;

	always_comb begin
		dreq = '0;
		if (st_q == ST_AVG) begin
			dreq.start = 1'b1;
			dreq.num = {18'd0, avg_sum} + {31'd0, samples_q[15:1]};
			dreq.den = {18'd0, samples_q};
		end else if (st_q == ST_NORM && num_s > 0) begin
			// numerator scaled to the load format plus half the divisor
			dreq.start = 1'b1;
			dreq.num = (46'(num_s[27:0]) << LOAD_FRAC_BITS) + (46'(span_u) << 15);
			dreq.den = {5'd0, span_u, 16'd0};
		end
	end

	// write data for the record being processed
	always_comb begin
		wdata = rec_q;
		we = 1'b0;
		if (st_q == ST_INIT) begin
			we = 1'b1;
			wdata = '0;
			wdata.loaded = LOADED_DEFAULT;
		end else if (st_q == ST_WB) begin
			we = 1'b1;
		end
	end

	assign s_tready = (st_q == ST_IDLE) && !mvalid_q;
	assign m_tvalid = mvalid_q;
	assign m_tdata = mdata_q;

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_tvalid && s_tready) in_q <= s_tdata;
		if (st_q == ST_WAIT) rec_q <= rd;
		// per-channel modify before write back
		if (st_q == ST_FILT) begin
			if (act_accum_q) rec_q.sum <= rec_q.sum + {16'd0, x};
			if (act_restore_q) begin
				rec_q.unloaded <= '0;
				rec_q.loaded <= LOADED_DEFAULT;
				rec_q.load <= '0;
				rec_q.contact <= 1'b0;
			end
			if (act_begin_q) rec_q.sum <= '0;
			if (act_proc_q) rec_q.filt <= fnew;
		end
		if (st_q == ST_AVGW && drsp.done) begin
			if (avg_phase_q == PH_UNLOADED) rec_q.unloaded <= drsp.quo[11:0];
			else rec_q.loaded <= drsp.quo[11:0];
		end
		if (st_q == ST_NORMW && (drsp.done || num_s <= 0)) begin
			rec_q.load <= ldn;
			rec_q.contact <= cnew;
		end
		// held loads and contacts start cleared with the memory sweep
		if (st_q == ST_INIT) begin
			ld_q[ch_q] <= '0;
			ct_q[ch_q] <= 1'b0;
		end
		if (st_q == ST_WB) begin
			ld_q[ch_q] <= rec_q.load;
			ct_q[ch_q] <= rec_q.contact;
		end
		if (st_q == ST_TORQ) begin
			rt_q <= (act_proc_q && en_q) ? torq(pair_q ? ld_q[2] : ld_q[0], maxt_q) : '0;
			lt_q <= (act_proc_q && en_q) ? torq(pair_q ? ld_q[3] : ld_q[1], maxt_q) : '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT;
			ch_q <= '0;
			phase_q <= PH_IDLE;
			seeded_q <= 1'b0;
			samples_q <= '0;
			elapsed_q <= '0;
			mvalid_q <= 1'b0;
			act_restore_q <= 1'b0;
			act_begin_q <= 1'b0;
			act_accum_q <= 1'b0;
			act_avg_q <= 1'b0;
			act_proc_q <= 1'b0;
			seed_tick_q <= 1'b0;
			avg_phase_q <= PH_IDLE;
		end else begin
			if (mvalid_q && m_tready) mvalid_q <= 1'b0;
			unique case (st_q)
				ST_INIT: begin
					ch_q <= ch_q + 1'b1;
					if (ch_q == CH_W'(CHANNELS - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (s_tvalid && s_tready) st_q <= ST_CTRL;
				ST_CTRL: begin
					ch_q <= '0;
					act_restore_q <= assist && do_restore;
					act_begin_q <= assist && do_begin;
					act_accum_q <= assist && running;
					act_avg_q <= assist && running && cal_end;
					act_proc_q <= assist && (running ? cal_end : !do_begin);
					seed_tick_q <= !seeded_q || do_restore || running;
					avg_phase_q <= phase_q;
					if (!assist) begin
						seeded_q <= 1'b0;
						if (running) elapsed_q <= elapsed_nx;
						st_q <= ST_TORQ;
					end else begin
						if (running && samples_q != 16'hFFFF) samples_q <= samples_q + 1'b1;
						st_q <= ST_RD;
						if (do_restore) begin
							phase_q <= PH_IDLE;
							seeded_q <= 1'b1;
						end else if (do_begin) begin
							samples_q <= '0;
							elapsed_q <= '0;
							phase_q <= c_unl ? PH_UNLOADED : PH_LOADED;
						end else if (running) begin
							elapsed_q <= elapsed_nx;
							if (cal_end) begin
								phase_q <= PH_DONE;
								seeded_q <= 1'b1;
							end
						end else begin
							seeded_q <= 1'b1;
						end
					end
				end
				ST_RD: st_q <= ST_WAIT;
				ST_WAIT: st_q <= ST_FILT;
				ST_FILT: st_q <= (act_avg_q && samples_q != '0) ? ST_AVG :
					(act_proc_q ? ST_NORM : ST_WB);
				ST_AVG: st_q <= ST_AVGW;
				ST_AVGW: if (drsp.done) st_q <= act_proc_q ? ST_NORM : ST_WB;
				ST_NORM: st_q <= ST_NORMW;
				ST_NORMW: if (drsp.done || num_s <= 0) st_q <= ST_WB;
				ST_WB: begin
					ch_q <= ch_q + 1'b1;
					st_q <= (ch_q == CH_W'(CHANNELS - 1)) ? ST_TORQ : ST_RD;
				end
				ST_TORQ: st_q <= ST_OUT;
				ST_OUT: begin
					mvalid_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT) begin
			mdata_q <= {2'd0, phase_q, ct_q, ld_q[3], ld_q[2], ld_q[1], ld_q[0], lt_q, rt_q};
		end
	end
endmodule
